// ===== sv/ihc_pkg.sv =====
// Shared types and constants for the IPv4 header classifier.
package ihc_pkg;

  localparam int unsigned LINK_BYTES_W = 7;
  localparam int unsigned CFG_DATA_W   = 7;

  localparam logic [LINK_BYTES_W-1:0] LINK_BYTES_RESET = 7'd14;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_LINK_HEADER_BYTES   = 1'b0,
    CFG_CHECKSUM_CHECK_EN   = 1'b1
  } cfg_index_t;

  // Byte offsets within the IPv4 header; OFF_TCP_DOFF counts from the end of it
  localparam logic [15:0] OFF_VER_IHL    = 16'd0;
  localparam logic [15:0] OFF_LEN_HI     = 16'd2;
  localparam logic [15:0] OFF_LEN_LO     = 16'd3;
  localparam logic [15:0] OFF_FRAG_HI    = 16'd6;
  localparam logic [15:0] OFF_FRAG_LO    = 16'd7;
  localparam logic [15:0] OFF_PROTOCOL   = 16'd9;
  localparam logic [15:0] OFF_CSUM_HI    = 16'd10;
  localparam logic [15:0] OFF_CSUM_LO    = 16'd11;
  localparam logic [15:0] OFF_TCP_DOFF   = 16'd12;
  localparam logic [15:0] POSITION_MAX   = 16'hffff;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [16:0] TCP_MIN_HEADER  = 17'd20;
  localparam logic [5:0]  ICMP_HEADER_LEN = 6'd4;
  localparam logic [5:0]  UDP_HEADER_LEN  = 6'd8;

  typedef enum logic [2:0] {
    VERDICT_BAD_CHECKSUM  = 3'd0,
    VERDICT_CORRUPT       = 3'd1,
    VERDICT_UNSUPPORTED   = 3'd2,
    VERDICT_TCP           = 3'd3,
    VERDICT_TCP_FRAG_HEAD = 3'd4,
    VERDICT_ICMP          = 3'd5,
    VERDICT_UDP           = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [LINK_BYTES_W-1:0] link_header_bytes;
    logic                    checksum_check_enable;
  } cfg_t;

  // Header fields and running sum gathered over one frame
  typedef struct packed {
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [15:0] flags_offset;
    logic [7:0]  protocol_number;
    logic [15:0] stored_checksum;
    logic [15:0] checksum_sum;
    logic [3:0]  tcp_offset_words;
  } frame_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [5:0]  ip_header_length;
    logic [5:0]  transport_header_length;
    logic [15:0] payload_length;
    logic        first_fragment;
    logic        later_fragment;
  } result_t;

endpackage

// ===== sv/ihc_parser.sv =====
// Byte input register, per-frame header capture and checksum sum, frame snapshot.
module ihc_parser (
  input  logic             clk,
  input  logic             rst,
  input  ihc_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       frame_byte,
  input  logic             last_byte,
  output logic             snap_valid,
  input  logic             snap_take,
  output ihc_pkg::frame_t  snap
);

  logic            hold_valid;
  logic [7:0]      hold_byte;
  logic            hold_last;
  logic            hold_go;
  logic            snap_ready;

  logic [15:0]     byte_position;
  logic [15:0]     byte_position_next;
  ihc_pkg::frame_t frame;
  ihc_pkg::frame_t frame_next;

  logic [15:0]     link_start;
  logic [15:0]     off;
  logic [5:0]      hlen;
  logic [15:0]     sum_part;
  logic [16:0]     sum_wide;

  assign snap_ready = !snap_valid || snap_take;
  // only a last byte can wait, and only on a full snapshot
  assign hold_go    = hold_valid && (!hold_last || snap_ready);
  assign in_ready   = !hold_valid || hold_go;
  assign link_start = {9'd0, cfg.link_header_bytes};

  always_comb begin
    frame_next = frame;
    off        = byte_position - link_start;
    hlen       = {frame.header_words, 2'b00};
    sum_part   = off[0] ? {8'd0, hold_byte} : {hold_byte, 8'd0};
    sum_wide   = {1'b0, frame.checksum_sum} + {1'b0, sum_part};
    if (byte_position >= link_start) begin
      if (off == ihc_pkg::OFF_VER_IHL) begin
        frame_next.header_words = hold_byte[3:0];
      end
      hlen = {frame_next.header_words, 2'b00};
      if (off == ihc_pkg::OFF_LEN_HI)   frame_next.total_length[15:8]    = hold_byte;
      if (off == ihc_pkg::OFF_LEN_LO)   frame_next.total_length[7:0]     = hold_byte;
      if (off == ihc_pkg::OFF_FRAG_HI)  frame_next.flags_offset[15:8]    = hold_byte;
      if (off == ihc_pkg::OFF_FRAG_LO)  frame_next.flags_offset[7:0]     = hold_byte;
      if (off == ihc_pkg::OFF_PROTOCOL) frame_next.protocol_number       = hold_byte;
      if (off == ihc_pkg::OFF_CSUM_HI)  frame_next.stored_checksum[15:8] = hold_byte;
      if (off == ihc_pkg::OFF_CSUM_LO)  frame_next.stored_checksum[7:0]  = hold_byte;
      // end-around carry keeps the sum folded to 16 bits
      if (off < {10'd0, hlen} && off != ihc_pkg::OFF_CSUM_HI &&
          off != ihc_pkg::OFF_CSUM_LO) begin
        frame_next.checksum_sum = sum_wide[15:0] + {15'd0, sum_wide[16]};
      end
      if (off == {10'd0, hlen} + ihc_pkg::OFF_TCP_DOFF) begin
        frame_next.tcp_offset_words = hold_byte[7:4];
      end
    end
    byte_position_next = (byte_position < ihc_pkg::POSITION_MAX) ?
                         byte_position + 16'd1 : byte_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (hold_go) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= frame_byte;
      hold_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 16'd0;
      frame         <= '0;
    end else if (hold_go) begin
      if (hold_last) begin
        byte_position <= 16'd0;
        frame         <= '0;
      end else begin
        byte_position <= byte_position_next;
        frame         <= frame_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (hold_go && hold_last) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_go && hold_last) begin
      snap <= frame_next;
    end
  end

endmodule

// ===== sv/ihc_judge.sv =====
// Verdict and length calculation from a frame snapshot, with the result register.
module ihc_judge (
  input  logic             clk,
  input  logic             rst,
  input  ihc_pkg::cfg_t    cfg,
  input  logic             snap_valid,
  input  ihc_pkg::frame_t  snap,
  output logic             snap_take,
  output logic             out_valid,
  input  logic             out_ready,
  output ihc_pkg::result_t result
);

  ihc_pkg::result_t   res_next;
  logic               judge_ready;
  logic [5:0]         hlen;
  logic signed [16:0] rest;
  logic signed [16:0] tcp_data;
  logic [5:0]         tcp_thl;
  logic               later;
  logic               first;
  logic               csum_bad;

  assign judge_ready = !out_valid || out_ready;
  assign snap_take   = snap_valid && judge_ready;

  assign hlen     = {snap.header_words, 2'b00};
  assign rest     = $signed({1'b0, snap.total_length}) - $signed({11'd0, hlen});
  assign tcp_thl  = {snap.tcp_offset_words, 2'b00};
  assign tcp_data = rest - $signed({11'd0, tcp_thl});
  assign later    = snap.flags_offset[12:0] != 13'd0;
  assign first    = snap.flags_offset[13] && !later;
  assign csum_bad = cfg.checksum_check_enable &&
                    ((~snap.checksum_sum) != snap.stored_checksum);

  always_comb begin
    res_next                         = '0;
    res_next.ip_header_length        = hlen;
    res_next.first_fragment          = first;
    res_next.later_fragment          = later;
    res_next.verdict                 = ihc_pkg::VERDICT_UNSUPPORTED;
    if (csum_bad) begin
      res_next.verdict        = ihc_pkg::VERDICT_BAD_CHECKSUM;
      res_next.first_fragment = 1'b0;
      res_next.later_fragment = 1'b0;
    end else if (snap.protocol_number == ihc_pkg::PROTO_TCP) begin
      priority if (later || (rest < $signed(ihc_pkg::TCP_MIN_HEADER) && first)) begin
        if (rest < 0) begin
          res_next.verdict = ihc_pkg::VERDICT_CORRUPT;
        end else begin
          res_next.verdict        = later ? ihc_pkg::VERDICT_TCP
                                          : ihc_pkg::VERDICT_TCP_FRAG_HEAD;
          res_next.payload_length = rest[15:0];
        end
      end else if (rest < $signed(ihc_pkg::TCP_MIN_HEADER)) begin
        res_next.verdict = ihc_pkg::VERDICT_CORRUPT;
      end else if (tcp_data >= 0) begin
        res_next.verdict                 = ihc_pkg::VERDICT_TCP;
        res_next.transport_header_length = tcp_thl;
        res_next.payload_length          = tcp_data[15:0];
      end else if (first) begin
        // header runs past the data: report it as a fragment head
        res_next.verdict        = ihc_pkg::VERDICT_TCP_FRAG_HEAD;
        res_next.payload_length = rest[15:0];
      end else begin
        res_next.verdict                 = ihc_pkg::VERDICT_CORRUPT;
        res_next.transport_header_length = tcp_thl;
      end
    end else if (snap.protocol_number == ihc_pkg::PROTO_ICMP) begin
      if (!later && rest >= $signed({11'd0, ihc_pkg::ICMP_HEADER_LEN})) begin
        res_next.verdict                 = ihc_pkg::VERDICT_ICMP;
        res_next.transport_header_length = ihc_pkg::ICMP_HEADER_LEN;
        res_next.payload_length          = rest[15:0] - {10'd0, ihc_pkg::ICMP_HEADER_LEN};
      end
    end else if (snap.protocol_number == ihc_pkg::PROTO_UDP) begin
      if (!later && rest >= $signed({11'd0, ihc_pkg::UDP_HEADER_LEN})) begin
        res_next.verdict                 = ihc_pkg::VERDICT_UDP;
        res_next.transport_header_length = ihc_pkg::UDP_HEADER_LEN;
        res_next.payload_length          = rest[15:0] - {10'd0, ihc_pkg::UDP_HEADER_LEN};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      result <= res_next;
    end
  end

endmodule

// ===== sv/ipv4_header_classifier.sv =====
// Top level of the IPv4 header classifier: configuration registers and pipeline.
//
//  channel  handshake              payload
//  -------  ---------------------  ---------------------------------------------
//  in       in_valid / in_ready    frame_byte, last_byte
//  out      out_valid / out_ready  verdict, ip_header_length,
//                                  transport_header_length, payload_length,
//                                  first_fragment, later_fragment
//  cfg      cfg_write_enable       cfg_index, cfg_data (no read-back)
//
// One byte is accepted per cycle while in_ready is high. After the last byte is accepted, a
// result passes through the byte register, then frame snapshot, then result register.
// Reset (synchronous) sets link_header_bytes to 14, the checksum check on,
// and clears the frame state. Input stalls only when a last byte finds both
// the snapshot and the result register full while out_ready is low.
module ipv4_header_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_enable,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] frame_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] verdict,
  output logic [5:0] ip_header_length,
  output logic [5:0] transport_header_length,
  output logic [15:0] payload_length,
  output logic       first_fragment,
  output logic       later_fragment
);

  ihc_pkg::cfg_t    cfg;
  ihc_pkg::frame_t  snap;
  ihc_pkg::result_t result;
  logic             snap_valid;
  logic             snap_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_header_bytes     <= ihc_pkg::LINK_BYTES_RESET;
      cfg.checksum_check_enable <= 1'b1;
    end else if (cfg_write_enable) begin
      unique case (ihc_pkg::cfg_index_t'(cfg_index))
        ihc_pkg::CFG_LINK_HEADER_BYTES: cfg.link_header_bytes     <= cfg_data;
        ihc_pkg::CFG_CHECKSUM_CHECK_EN: cfg.checksum_check_enable <= cfg_data[0];
      endcase
    end
  end

  ihc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .snap_valid (snap_valid),
    .snap_take  (snap_take),
    .snap       (snap)
  );

  ihc_judge u_judge (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign verdict                 = result.verdict;
  assign ip_header_length        = result.ip_header_length;
  assign transport_header_length = result.transport_header_length;
  assign payload_length          = result.payload_length;
  assign first_fragment          = result.first_fragment;
  assign later_fragment          = result.later_fragment;

  // input may only back up behind a full snapshot and a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> snap_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

  a_new_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(snap_valid))
    else $error("result appeared without a snapshot");

  a_bad_checksum_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == ihc_pkg::VERDICT_BAD_CHECKSUM |->
      transport_header_length == 6'd0 && payload_length == 16'd0 &&
      !first_fragment && !later_fragment)
    else $error("bad checksum result carries fields");

  a_fragment_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(first_fragment && later_fragment))
    else $error("first and later fragment both set");

endmodule

// ===== test/ipv4_header_classifier_tb.sv =====
// Testbench for the IPv4 header classifier: frame stimulus, byte-level predictor, result check.
`timescale 1ns / 1ps

module ipv4_header_classifier_tb;

  typedef logic [7:0] byte_q_t[$];

  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int MAX_REPORTS    = 10;

  logic       clk;
  logic       rst;
  logic       cfg_write_enable;
  ihc_pkg::cfg_index_t cfg_index;
  logic [6:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] verdict;
  logic [5:0] ip_header_length;
  logic [5:0] transport_header_length;
  logic [15:0] payload_length;
  logic       first_fragment;
  logic       later_fragment;

  int send_idle_pct;
  int recv_idle_pct;
  int holdoff_requests;
  int error_count;

  // Predictor state
  ihc_pkg::cfg_t    cfg_model;
  ihc_pkg::frame_t  hdr_state;
  logic [15:0]      byte_pos;
  ihc_pkg::result_t verdict_queue[$];

  ipv4_header_classifier u_top (
    .clk                     (clk),
    .rst                     (rst),
    .cfg_write_enable        (cfg_write_enable),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .frame_byte              (frame_byte),
    .last_byte               (last_byte),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .verdict                 (verdict),
    .ip_header_length        (ip_header_length),
    .transport_header_length (transport_header_length),
    .payload_length          (payload_length),
    .first_fragment          (first_fragment),
    .later_fragment          (later_fragment)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] part);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, part};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic void clear_frame_state();
    hdr_state = '0;
    byte_pos  = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [15:0] off;
    int hlen;
    if (byte_pos >= {9'd0, cfg_model.link_header_bytes}) begin
      off = byte_pos - {9'd0, cfg_model.link_header_bytes};
      if (off == ihc_pkg::OFF_VER_IHL) hdr_state.header_words = b[3:0];
      hlen = int'(hdr_state.header_words) * 4;
      if (off == ihc_pkg::OFF_LEN_HI)   hdr_state.total_length[15:8]    = b;
      if (off == ihc_pkg::OFF_LEN_LO)   hdr_state.total_length[7:0]     = b;
      if (off == ihc_pkg::OFF_FRAG_HI)  hdr_state.flags_offset[15:8]    = b;
      if (off == ihc_pkg::OFF_FRAG_LO)  hdr_state.flags_offset[7:0]     = b;
      if (off == ihc_pkg::OFF_PROTOCOL) hdr_state.protocol_number       = b;
      if (off == ihc_pkg::OFF_CSUM_HI)  hdr_state.stored_checksum[15:8] = b;
      if (off == ihc_pkg::OFF_CSUM_LO)  hdr_state.stored_checksum[7:0]  = b;
      // checksum field itself counts as zero
      if (int'(off) < hlen && off != ihc_pkg::OFF_CSUM_HI && off != ihc_pkg::OFF_CSUM_LO)
        hdr_state.checksum_sum = ones_add(hdr_state.checksum_sum,
                                          off[0] ? {8'h00, b} : {b, 8'h00});
      if (int'(off) == hlen + int'(ihc_pkg::OFF_TCP_DOFF))
        hdr_state.tcp_offset_words = b[7:4];
    end
    if (byte_pos != ihc_pkg::POSITION_MAX) byte_pos = byte_pos + 16'd1;
  endfunction

  function automatic ihc_pkg::result_t classify_frame();
    ihc_pkg::result_t r;
    int hlen;
    int rest;
    int thl;
    int data;
    logic later;
    logic first;
    hlen  = int'(hdr_state.header_words) * 4;
    rest  = int'(hdr_state.total_length) - hlen;
    thl   = 0;
    data  = 0;
    later = (hdr_state.flags_offset[12:0] != 13'd0);
    first = hdr_state.flags_offset[13] && !later;
    if (cfg_model.checksum_check_enable &&
        ((~hdr_state.checksum_sum) != hdr_state.stored_checksum)) begin
      r.verdict = ihc_pkg::VERDICT_BAD_CHECKSUM;
      later = 1'b0;
      first = 1'b0;
    end else if (hdr_state.protocol_number == ihc_pkg::PROTO_TCP) begin
      if (later) begin
        data = rest;
        r.verdict = ihc_pkg::VERDICT_TCP;
        if (data < 0) begin
          data = 0;
          r.verdict = ihc_pkg::VERDICT_CORRUPT;
        end
      end else if (rest < int'(ihc_pkg::TCP_MIN_HEADER)) begin
        if (first) begin
          data = rest;
          r.verdict = ihc_pkg::VERDICT_TCP_FRAG_HEAD;
          if (data < 0) begin
            data = 0;
            r.verdict = ihc_pkg::VERDICT_CORRUPT;
          end
        end else begin
          r.verdict = ihc_pkg::VERDICT_CORRUPT;
        end
      end else begin
        thl  = int'(hdr_state.tcp_offset_words) * 4;
        data = rest - thl;
        r.verdict = ihc_pkg::VERDICT_TCP;
        if (data < 0) begin
          if (first) begin
            thl  = 0;
            data = rest;
            r.verdict = ihc_pkg::VERDICT_TCP_FRAG_HEAD;
          end else begin
            data = 0;
            r.verdict = ihc_pkg::VERDICT_CORRUPT;
          end
        end
      end
    end else if (hdr_state.protocol_number == ihc_pkg::PROTO_ICMP) begin
      if (later || rest < int'(ihc_pkg::ICMP_HEADER_LEN)) begin
        r.verdict = ihc_pkg::VERDICT_UNSUPPORTED;
      end else begin
        thl  = int'(ihc_pkg::ICMP_HEADER_LEN);
        data = rest - thl;
        r.verdict = ihc_pkg::VERDICT_ICMP;
      end
    end else if (hdr_state.protocol_number == ihc_pkg::PROTO_UDP) begin
      if (later || rest < int'(ihc_pkg::UDP_HEADER_LEN)) begin
        r.verdict = ihc_pkg::VERDICT_UNSUPPORTED;
      end else begin
        thl  = int'(ihc_pkg::UDP_HEADER_LEN);
        data = rest - thl;
        r.verdict = ihc_pkg::VERDICT_UDP;
      end
    end else begin
      r.verdict = ihc_pkg::VERDICT_UNSUPPORTED;
    end
    r.ip_header_length        = 6'(hlen);
    r.transport_header_length = 6'(thl);
    r.payload_length          = 16'(data);
    r.first_fragment          = first;
    r.later_fragment          = later;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    frame_byte <= b;
    last_byte  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_byte(b);
    if (last) begin
      verdict_queue.push_back(classify_frame());
      clear_frame_state();
    end
  endtask

  task automatic send_frame(input byte_q_t pkt);
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Drop valid, then hold until every verdict has come back and the pipe is empty
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input ihc_pkg::cfg_index_t idx, input logic [6:0] value);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    unique case (idx)
      ihc_pkg::CFG_LINK_HEADER_BYTES: cfg_model.link_header_bytes     = value;
      ihc_pkg::CFG_CHECKSUM_CHECK_EN: cfg_model.checksum_check_enable = value[0];
    endcase
  endtask

  task automatic configure(input logic [6:0] link_n, input logic csum_en);
    wait_drained();
    write_cfg(ihc_pkg::CFG_LINK_HEADER_BYTES, link_n);
    write_cfg(ihc_pkg::CFG_CHECKSUM_CHECK_EN, {6'd0, csum_en});
  endtask

  // Link header, IPv4 header with options, transport header, payload; optionally cut short
  task automatic build_frame(input int link_n, input logic [3:0] ihl, input logic [15:0] tot,
                             input logic [15:0] frag, input logic [7:0] proto,
                             input logic [3:0] doff, input bit csum_ok, input int payload_n,
                             input int keep_n, output byte_q_t pkt);
    logic [7:0]  ip[$];
    logic [15:0] sum;
    logic [15:0] csum;
    int hlen;
    int n;
    hlen = int'(ihl) * 4;
    n    = hlen + 20 + payload_n;
    ip   = {};
    repeat (n) ip.push_back(8'($urandom));
    ip[0] = {(($urandom_range(7) == 0) ? 4'($urandom) : 4'd4), ihl};
    ip[2] = tot[15:8];
    ip[3] = tot[7:0];
    ip[6] = frag[15:8];
    ip[7] = frag[7:0];
    ip[9] = proto;
    ip[hlen + 12] = {doff, 4'($urandom)};
    sum = 16'h0000;
    for (int i = 0; i < hlen; i++)
      if (i != 10 && i != 11) sum = ones_add(sum, (i % 2) ? {8'h00, ip[i]} : {ip[i], 8'h00});
    csum = ~sum;
    if (!csum_ok) csum = csum ^ 16'($urandom_range(1, 16'hffff));
    ip[10] = csum[15:8];
    ip[11] = csum[7:0];
    pkt = {};
    repeat (link_n) pkt.push_back(8'($urandom));
    if (keep_n >= 0 && keep_n < n) n = keep_n;
    for (int i = 0; i < n; i++) pkt.push_back(ip[i]);
    if (pkt.size() == 0) pkt.push_back(8'($urandom));
  endtask

  task automatic send_ipv4(input int link_n, input logic [3:0] ihl, input logic [15:0] tot,
                           input logic [15:0] frag, input logic [7:0] proto,
                           input logic [3:0] doff, input bit csum_ok, input int payload_n,
                           input int keep_n);
    byte_q_t pkt;
    build_frame(link_n, ihl, tot, frag, proto, doff, csum_ok, payload_n, keep_n, pkt);
    send_frame(pkt);
  endtask

  task automatic send_random_frame(output int n_bytes);
    byte_q_t pkt;
    int sel;
    int link_n;
    int hlen;
    int thl_guess;
    int payload_n;
    int keep_n;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    logic [15:0] frag;
    logic [15:0] tot;
    if ($urandom_range(99) < 8) begin
      // noise: random bytes of random length
      pkt = {};
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
    end else begin
      link_n = ($urandom_range(9) == 0) ? $urandom_range(0, 64)
                                        : int'(cfg_model.link_header_bytes);
      ihl  = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8));
      doff = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8));
      sel  = $urandom_range(99);
      if (sel < 35)      proto = ihc_pkg::PROTO_TCP;
      else if (sel < 60) proto = ihc_pkg::PROTO_UDP;
      else if (sel < 80) proto = ihc_pkg::PROTO_ICMP;
      else               proto = 8'($urandom);
      sel = $urandom_range(99);
      if (sel < 50)      frag = {1'b0, 1'($urandom), 14'd0};
      else if (sel < 70) frag = {1'($urandom), 1'($urandom), 1'b1, 13'd0};
      else if (sel < 85) frag = {3'($urandom), 13'($urandom_range(1, 200))};
      else               frag = 16'($urandom);
      payload_n = $urandom_range(0, 8);
      hlen = int'(ihl) * 4;
      if (proto == ihc_pkg::PROTO_TCP)       thl_guess = int'(doff) * 4;
      else if (proto == ihc_pkg::PROTO_UDP)  thl_guess = int'(ihc_pkg::UDP_HEADER_LEN);
      else if (proto == ihc_pkg::PROTO_ICMP) thl_guess = int'(ihc_pkg::ICMP_HEADER_LEN);
      else                                   thl_guess = $urandom_range(0, 20);
      sel = $urandom_range(99);
      if (sel < 70)      tot = 16'(hlen + thl_guess + payload_n);
      else if (sel < 85) tot = 16'(hlen + $urandom_range(0, 30));
      else               tot = 16'($urandom);
      keep_n = ($urandom_range(9) == 0) ? $urandom_range(0, hlen + 24) : -1;
      build_frame(link_n, ihl, tot, frag, proto, doff, $urandom_range(99) < 85,
                  payload_n, keep_n, pkt);
    end
    n_bytes = pkt.size();
    send_frame(pkt);
  endtask

  task automatic test_reset_defaults();
    send_ipv4(14, 4'd5, 16'd46, 16'h4000, ihc_pkg::PROTO_TCP, 4'd5, 1'b1, 6, -1);
    send_ipv4(14, 4'd5, 16'd46, 16'h0000, ihc_pkg::PROTO_TCP, 4'd5, 1'b0, 6, -1);
    wait_drained();
  endtask

  task automatic test_protocol_dispatch();
    byte_q_t pkt;
    configure(7'd0, 1'b0);
    send_ipv4(0, 4'd5, 16'd30, 16'h0010, ihc_pkg::PROTO_TCP, 4'd5, 1'b1, 0, 12);
    send_ipv4(0, 4'd5, 16'd10, 16'h0010, ihc_pkg::PROTO_TCP, 4'd5, 1'b1, 0, 12);
    send_ipv4(0, 4'd5, 16'd30, 16'h2000, ihc_pkg::PROTO_TCP, 4'd5, 1'b1, 0, 12);
    send_ipv4(0, 4'd5, 16'd12, 16'h2000, ihc_pkg::PROTO_TCP, 4'd5, 1'b1, 0, 12);
    send_ipv4(0, 4'd5, 16'd30, 16'h0000, ihc_pkg::PROTO_TCP, 4'd5, 1'b1, 0, 12);
    // data offset longer than what remains, plain and as fragment head
    send_ipv4(0, 4'd5, 16'd50, 16'h0000, ihc_pkg::PROTO_TCP, 4'd15, 1'b1, 0, -1);
    send_ipv4(0, 4'd5, 16'd50, 16'h2000, ihc_pkg::PROTO_TCP, 4'd15, 1'b1, 0, -1);
    send_ipv4(0, 4'd5, 16'd24, 16'h0000, ihc_pkg::PROTO_ICMP, 4'd5, 1'b1, 0, 12);
    send_ipv4(0, 4'd5, 16'd23, 16'h0000, ihc_pkg::PROTO_ICMP, 4'd5, 1'b1, 0, 12);
    send_ipv4(0, 4'd5, 16'd100, 16'h1fff, ihc_pkg::PROTO_ICMP, 4'd5, 1'b1, 0, 12);
    // length fields whose byte order matters for the UDP length test
    send_ipv4(0, 4'd5, 16'h1c00, 16'h0000, ihc_pkg::PROTO_UDP, 4'd5, 1'b1, 0, 12);
    send_ipv4(0, 4'd5, 16'h001b, 16'h0000, ihc_pkg::PROTO_UDP, 4'd5, 1'b1, 0, 12);
    send_ipv4(0, 4'd15, 16'hffff, 16'he000, 8'hff, 4'd15, 1'b1, 0, 12);
    pkt = {8'hff};
    send_frame(pkt);
    pkt = {8'h00};
    send_frame(pkt);
    wait_drained();
  endtask

  task automatic test_checksum_rules();
    byte_q_t pkt;
    configure(7'd0, 1'b1);
    send_ipv4(0, 4'd15, 16'd83, 16'h0000, ihc_pkg::PROTO_TCP, 4'd5, 1'b1, 3, -1);
    send_ipv4(0, 4'd6, 16'd40, 16'h0000, ihc_pkg::PROTO_UDP, 4'd5, 1'b0, 2, -1);
    // zero IHL: empty sum, so only 0xffff passes
    send_ipv4(0, 4'd0, 16'd8, 16'h0000, ihc_pkg::PROTO_UDP, 4'd5, 1'b1, 0, 12);
    pkt = {8'h40};
    send_frame(pkt);
    // short frame: missing header bytes read as zero
    send_ipv4(0, 4'd5, 16'd28, 16'h0000, ihc_pkg::PROTO_UDP, 4'd5, 1'b1, 0, 6);
    wait_drained();
  endtask

  task automatic test_midframe_config();
    byte_q_t pkt;
    configure(7'd0, 1'b1);
    build_frame(0, 4'd5, 16'd40, 16'h0000, ihc_pkg::PROTO_TCP, 4'd5, 1'b1, 0, -1, pkt);
    for (int i = 0; i < 6; i++) send_byte(pkt[i], 1'b0);
    wait_drained();
    write_cfg(ihc_pkg::CFG_LINK_HEADER_BYTES, 7'd3);
    write_cfg(ihc_pkg::CFG_CHECKSUM_CHECK_EN, 7'd0);
    for (int i = 6; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int s_idle, input int r_idle, input int n_target);
    int sent;
    int frames;
    int n;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent   = 0;
    frames = 0;
    while (sent < n_target || frames < 16) begin
      send_random_frame(n);
      sent   = sent + n;
      frames = frames + 1;
    end
    wait_drained();
  endtask

  // Hold the output back while short frames keep coming, so the input stalls
  task automatic test_output_stall();
    byte_q_t pkt;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_requests = holdoff_requests + 1;
    repeat (40) begin
      pkt = {};
      repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
      send_frame(pkt);
    end
    wait_drained();
  endtask

  task automatic check_result();
    ihc_pkg::result_t want;
    if (verdict_queue.size() == 0) begin
      error_count = error_count + 1;
      if (error_count <= MAX_REPORTS)
        $display("unexpected result: verdict %0d iphl %0d thl %0d payload %0d first %0d later %0d",
                 verdict, ip_header_length, transport_header_length, payload_length,
                 first_fragment, later_fragment);
    end else begin
      want = verdict_queue.pop_front();
      if (verdict !== want.verdict ||
          ip_header_length !== want.ip_header_length ||
          transport_header_length !== want.transport_header_length ||
          payload_length !== want.payload_length ||
          first_fragment !== want.first_fragment ||
          later_fragment !== want.later_fragment) begin
        error_count = error_count + 1;
        if (error_count <= MAX_REPORTS) begin
          $display("mismatch expected: verdict %0d iphl %0d thl %0d payload %0d first %0d later %0d",
                   want.verdict, want.ip_header_length, want.transport_header_length,
                   want.payload_length, want.first_fragment, want.later_fragment);
          $display("         actual:   verdict %0d iphl %0d thl %0d payload %0d first %0d later %0d",
                   verdict, ip_header_length, transport_header_length, payload_length,
                   first_fragment, later_fragment);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
  end

  initial begin : receiver
    int served;
    int hold_left;
    served    = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_requests > served) begin
        served    = served + 1;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run if no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    frame_byte       = 8'h00;
    last_byte        = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_index        = ihc_pkg::CFG_LINK_HEADER_BYTES;
    cfg_data         = 7'd0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    holdoff_requests = 0;
    error_count      = 0;
    cfg_model.link_header_bytes     = ihc_pkg::LINK_BYTES_RESET;
    cfg_model.checksum_check_enable = 1'b1;
    clear_frame_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_protocol_dispatch();
    test_checksum_rules();
    test_midframe_config();

    configure(7'd14, 1'b1);
    test_random_traffic(16, 76, 450);
    configure(7'd64, 1'b1);
    test_random_traffic(76, 16, 450);
    configure(7'($urandom_range(1, 63)), 1'b0);
    test_random_traffic(0, 0, 400);
    test_output_stall();

    wait_drained();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ihc_pkg.sv
sv/ihc_parser.sv
sv/ihc_judge.sv
sv/ipv4_header_classifier.sv
test/ipv4_header_classifier_tb.sv
